[design/gsel_pkg.sv]
// gselect predictor package: word types, register codes, counter update
// no dependencies
`timescale 1ns / 1ps

package gsel_pkg;

  localparam int DEF_MAX_INDEX_BITS   = 8;
  localparam int DEF_MAX_HISTORY_BITS = 4;

  localparam logic [1:0] CTR_INIT = 2'd3;

  // register index taken from paddr[2]
  localparam logic REG_INDEX_BITS   = 1'b0;
  localparam logic REG_HISTORY_BITS = 1'b1;

  typedef struct packed {
    logic [31:0] branch_address;
    logic        taken;
  } gsel_in_t;

  typedef struct packed {
    logic prediction;
    logic mispredicted;
  } gsel_out_t;

  typedef struct packed {
    logic rd_en;  // word accepted, read its counter
    logic wr_en;  // stage one retires, write its counter back
  } gsel_ctl_t;

  // 2-bit counter with hysteresis, prediction is the msb
  function automatic logic [1:0] gsel_next_ctr(input logic [1:0] c, input logic tk);
    logic [1:0] n;
    n = c;
    if (c[1] == tk) begin
      unique case (c)
        2'd2:    n = 2'd3;
        2'd1:    n = 2'd0;
        default: n = c;
      endcase
    end else if (c[1]) begin
      unique case (c)
        2'd3:    n = 2'd2;
        2'd2:    n = 2'd0;
        default: n = c;
      endcase
    end else begin
      unique case (c)
        2'd0:    n = 2'd1;
        2'd1:    n = 2'd3;
        default: n = c;
      endcase
    end
    return n;
  endfunction

endpackage

[design/gsel_hist.sv]
// global history register and counter index formation
// depends on gsel_pkg
`timescale 1ns / 1ps

module gsel_hist import gsel_pkg::*; #(
  parameter int MAX_INDEX_BITS   = DEF_MAX_INDEX_BITS,
  parameter int MAX_HISTORY_BITS = DEF_MAX_HISTORY_BITS,
  localparam int AW = (MAX_INDEX_BITS + MAX_HISTORY_BITS > 0) ?
                      (MAX_INDEX_BITS + MAX_HISTORY_BITS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [3:0]    index_bits,
  input  logic [2:0]    history_bits,
  input  logic          accept,
  input  gsel_in_t      in_word,
  output logic [AW-1:0] entry
);

  localparam int IW = (MAX_INDEX_BITS > 0) ? MAX_INDEX_BITS : 1;
  localparam int HW = (MAX_HISTORY_BITS > 0) ? MAX_HISTORY_BITS : 1;
  localparam int SW = IW + HW;

  logic [HW-1:0] hist_r;
  logic [HW-1:0] hist_nxt;
  logic [HW-1:0] hist_shift;
  logic [4:0]    m_eff;
  logic [3:0]    k_eff;
  logic [IW-1:0] row;
  logic [HW-1:0] col;
  logic [SW-1:0] entry_wide;

  // oversized settings saturate
  assign m_eff = ({1'b0, index_bits} > 5'(MAX_INDEX_BITS)) ?
                 5'(MAX_INDEX_BITS) : {1'b0, index_bits};
  assign k_eff = ({1'b0, history_bits} > 4'(MAX_HISTORY_BITS)) ?
                 4'(MAX_HISTORY_BITS) : {1'b0, history_bits};

  assign hist_shift = hist_r >> 1;

  always_comb begin
    for (int i = 0; i < IW; i++) begin
      row[i] = in_word.branch_address[i] & (5'(i) < m_eff);
    end
    for (int i = 0; i < HW; i++) begin
      col[i] = hist_r[i] & (4'(i) < k_eff);
      // low k bits shift right, outcome enters at bit k-1
      if (4'(i) + 4'd1 < k_eff) begin
        hist_nxt[i] = hist_shift[i];
      end else if (4'(i) + 4'd1 == k_eff) begin
        hist_nxt[i] = in_word.taken;
      end else begin
        hist_nxt[i] = hist_r[i];
      end
    end
  end

  assign entry_wide = (SW'(row) << MAX_HISTORY_BITS) | SW'(col);
  assign entry      = entry_wide[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '1;
    end else if (accept) begin
      hist_r <= hist_nxt;
    end
  end

endmodule

[design/gsel_table.sv]
// counter table memory with clearing sweep, read register and write bypass
// depends on gsel_pkg
`timescale 1ns / 1ps

module gsel_table import gsel_pkg::*; #(
  parameter int MAX_INDEX_BITS   = DEF_MAX_INDEX_BITS,
  parameter int MAX_HISTORY_BITS = DEF_MAX_HISTORY_BITS,
  localparam int AW = (MAX_INDEX_BITS + MAX_HISTORY_BITS > 0) ?
                      (MAX_INDEX_BITS + MAX_HISTORY_BITS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  gsel_ctl_t     ctl,
  input  logic [AW-1:0] rd_entry,
  input  logic          s1_taken,
  output logic          s1_pred,
  output logic          busy
);

  localparam int DEPTH = 1 << AW;

  logic [1:0]    mem [DEPTH];
  logic [1:0]    rdata_r;
  logic [AW-1:0] s1_entry_r;
  logic [1:0]    fwd_r;
  logic          fwd_hit_r;
  logic [AW-1:0] clr_addr_r;
  logic          clearing_r;
  logic [1:0]    cur_ctr;
  logic [1:0]    next_ctr;

  // previous word wrote this entry in the same cycle as the read
  assign cur_ctr  = fwd_hit_r ? fwd_r : rdata_r;
  assign next_ctr = gsel_next_ctr(cur_ctr, s1_taken);
  assign s1_pred  = cur_ctr[1];
  assign busy     = clearing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == '1) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_addr_r] <= CTR_INIT;
    end else if (ctl.wr_en) begin
      mem[s1_entry_r] <= next_ctr;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata_r    <= mem[rd_entry];
      s1_entry_r <= rd_entry;
      fwd_r      <= next_ctr;
      fwd_hit_r  <= ctl.wr_en && (rd_entry == s1_entry_r);
    end
  end

endmodule

[design/gselect_branch_predictor.sv]
// gselect branch predictor top: config registers, pipeline control, result register
// depends on gsel_pkg, gsel_hist, gsel_table
//
//   port group | direction | carries
//   in_*       | in        | gsel_in_t word: branch_address, taken
//   out_*      | out       | gsel_out_t word: prediction, mispredicted
//   APB        | in/out    | index_bits at 0x0, history_bits at 0x4
//
// one word per cycle while no sweep runs and the output is drained; an accepted word passes stage one,
// the registered table read, into the output register, and its counter is written back as it enters there
// after reset a sweep writes every counter, all 2^(MAX_INDEX_BITS+MAX_HISTORY_BITS)
// of them (4096 by default), with in_ready low; config writes are taken meanwhile
// out_ready low holds the result, stage one takes one more word, then in_ready drops
`timescale 1ns / 1ps

module gselect_branch_predictor import gsel_pkg::*; #(
  parameter int MAX_INDEX_BITS   = DEF_MAX_INDEX_BITS,
  parameter int MAX_HISTORY_BITS = DEF_MAX_HISTORY_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  gsel_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output gsel_out_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = (MAX_INDEX_BITS + MAX_HISTORY_BITS > 0) ?
                      (MAX_INDEX_BITS + MAX_HISTORY_BITS) : 1;

  logic [3:0]    index_bits_r;
  logic [2:0]    history_bits_r;
  logic          s1_valid_r;
  logic          s1_taken_r;
  logic          out_valid_r;
  gsel_out_t     out_data_r;
  logic          accept;
  logic          adv;
  logic          busy;
  logic          s1_pred;
  logic          cfg_wr;
  logic [AW-1:0] entry;
  gsel_ctl_t     ctl;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_bits_r   <= 4'd8;
      history_bits_r <= 3'd4;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_INDEX_BITS:   index_bits_r   <= pwdata[3:0];
        REG_HISTORY_BITS: history_bits_r <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_INDEX_BITS:   prdata = {28'd0, index_bits_r};
      REG_HISTORY_BITS: prdata = {29'd0, history_bits_r};
      default:          prdata = '0;
    endcase
  end

  // stage one retires when the output register is free or being drained
  assign adv       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !busy && (!s1_valid_r || adv);
  assign accept    = in_valid && in_ready;
  assign ctl.rd_en = accept;
  assign ctl.wr_en = adv;

  gsel_hist #(
    .MAX_INDEX_BITS   (MAX_INDEX_BITS),
    .MAX_HISTORY_BITS (MAX_HISTORY_BITS)
  ) u_hist (
    .clk          (clk),
    .rst_n        (rst_n),
    .index_bits   (index_bits_r),
    .history_bits (history_bits_r),
    .accept       (accept),
    .in_word      (in_data),
    .entry        (entry)
  );

  gsel_table #(
    .MAX_INDEX_BITS   (MAX_INDEX_BITS),
    .MAX_HISTORY_BITS (MAX_HISTORY_BITS)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .rd_entry (entry),
    .s1_taken (s1_taken_r),
    .s1_pred  (s1_pred),
    .busy     (busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_taken_r <= in_data.taken;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.prediction   <= s1_pred;
      out_data_r.mispredicted <= s1_pred ^ s1_taken_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // no word enters while the table sweep runs
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy && in_ready))
    else $error("word accepted during table clear");

  // reset always starts a clearing sweep
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("table clear not started by reset");

  // an accepted word is in stage one on the next cycle
  a_accept_s1: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted word lost before stage one");

  // stalled output keeps stage one occupied
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |=> s1_valid_r)
    else $error("stage one dropped while output stalled");

endmodule
